>>> hw/rtl/sorted_set_union_top_macros.svh
// assertion macros for the sorted set union block
// used by sorted_set_union_top.sv; no other dependencies
`ifndef SORTED_SET_UNION_TOP_MACROS_SVH
`define SORTED_SET_UNION_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ssu_pkg.sv
// shared types and constants for the sorted set union block
// no dependencies; used by ssu_cell and sorted_set_union_top
package ssu_pkg;

   // width of the value field on both channels
   localparam int IO_BITS   = 32;
   // widest internal value, used for sign extension in both directions
   localparam int WIDE_BITS = 64;

   // input beat
   typedef struct packed {
      logic signed [IO_BITS-1:0] value;
      logic                      last;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [IO_BITS-1:0] value_res;
      logic                      last_res;
      logic                      overflow;
   } rsp_type;

   // control handed from one cell to its right neighbor
   typedef struct packed {
      logic occ;  // cell holds a value
      logic gt;   // held value is greater than the broadcast value
   } link_type;

   // sequencer states
   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

endpackage

>>> hw/rtl/sorted_set_union_top.sv
// Sorted set union. Input beats carry signed values of both sets as one stream;
// each value enters a chain of CAPACITY cells that keeps the distinct values in
// ascending order, one input beat per cycle with no stall while filling. A
// value already held is ignored; a new distinct value that finds the chain full
// is dropped and the overflow flag is raised on the final result. On the beat
// marked last the value is inserted and the chain then drains from its low end,
// one result beat per cycle while the result side does not stall, so a batch
// with N distinct values holds off new input until all N results have left
// the chain. The chain is empty after the final result and the next batch
// may begin at once.
// depends on ssu_pkg, ssu_cell and sorted_set_union_top_macros.svh
`include "sorted_set_union_top_macros.svh"

module sorted_set_union_top #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssu_pkg::rsp_type rsp_data
);

   ssu_pkg::state_type           state_ff;
   ssu_pkg::state_type           state_in;
   logic                         req_acc;
   logic                         pop;
   logic                         ins_en;
   logic                         dup;
   logic                         full;
   logic                         final_pop;
   logic signed [ssu_pkg::WIDE_BITS-1:0] in_ext;
   logic signed [ssu_pkg::WIDE_BITS-1:0] out_ext;
   logic signed [VALUE_BITS-1:0] new_val;
   ssu_pkg::link_type            ctl [CAPACITY];
   logic signed [VALUE_BITS-1:0] val_chain [CAPACITY];
   logic [CAPACITY-1:0]          eq_vec;
   logic [CAPACITY-1:0]          occ_vec;
   logic                         dropped_ff;
   logic                         dropped_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ssu_pkg::rsp_type             rsp_data_ff;
   ssu_pkg::rsp_type             rsp_data_in;

   // input value to internal width
   assign in_ext  = ssu_pkg::WIDE_BITS'(req_data.value);
   assign new_val = in_ext[VALUE_BITS-1:0];

   // chain status
   assign dup       = |eq_vec;
   assign full      = ctl[CAPACITY-1].occ;
   assign req_acc   = req_valid & ~req_stall;
   assign ins_en    = req_acc & ~dup & ~full;
   assign final_pop = pop & ~ctl[1].occ;

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ssu_pkg::link_type            left_ctl;
      logic signed [VALUE_BITS-1:0] left_val;
      logic                         right_occ;
      logic signed [VALUE_BITS-1:0] right_val;

      if (i == 0) begin : g_head
         assign left_ctl.occ = 1'b1;
         assign left_ctl.gt  = 1'b0;
         assign left_val     = '0;
      end else begin : g_body
         assign left_ctl = ctl[i-1];
         assign left_val = val_chain[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_occ = 1'b0;
         assign right_val = '0;
      end else begin : g_next
         assign right_occ = ctl[i+1].occ;
         assign right_val = val_chain[i+1];
      end

      ssu_cell #(
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ins_en    (ins_en),
         .shift_en  (pop),
         .new_val   (new_val),
         .left_ctl  (left_ctl),
         .left_val  (left_val),
         .right_occ (right_occ),
         .right_val (right_val),
         .ctl       (ctl[i]),
         .val       (val_chain[i]),
         .eq        (eq_vec[i])
      );

      assign occ_vec[i] = ctl[i].occ;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssu_pkg::ST_FILL: begin
            if (req_acc && req_data.last) begin
               state_in = ssu_pkg::ST_DRAIN;
            end
         end
         ssu_pkg::ST_DRAIN: begin
            if (final_pop) begin
               state_in = ssu_pkg::ST_FILL;
            end
         end
         default: state_in = ssu_pkg::ST_FILL;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b0;
      pop       = 1'b0;
      case (state_ff)
         ssu_pkg::ST_FILL: begin
            req_stall = 1'b0;
         end
         ssu_pkg::ST_DRAIN: begin
            req_stall = 1'b1;
            pop       = ~rsp_valid_ff | ~rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssu_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   // dropped-value flag for the current batch
   always_comb begin
      dropped_in = dropped_ff;
      if (final_pop) begin
         dropped_in = 1'b0;
      end else if (req_acc && full && !dup) begin
         dropped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dropped_ff <= 1'b0;
      end else begin
         dropped_ff <= dropped_in;
      end
   end

   // result register fed from the low end of the chain
   assign out_ext = ssu_pkg::WIDE_BITS'(val_chain[0]);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value_res = out_ext[ssu_pkg::IO_BITS-1:0];
         rsp_data_in.last_res  = ~ctl[1].occ;
         rsp_data_in.overflow  = ~ctl[1].occ & dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `SSU_ASSERT_NOW(a_occ_packed, clock, reset, 1'b1,
      (occ_vec & (occ_vec + 1'b1)) == '0, "chain occupancy has a hole")
   `SSU_ASSERT_NEXT(a_empty_after_drain, clock, reset, final_pop,
      (occ_vec == '0) && (state_ff == ssu_pkg::ST_FILL) && !dropped_ff,
      "chain not empty after final result")
   `SSU_ASSERT_NOW(a_overflow_on_last, clock, reset, rsp_valid,
      !rsp_data.overflow || rsp_data.last_res, "overflow on a non-final result")
   `SSU_ASSERT_NOW(a_drain_nonempty, clock, reset, pop,
      ctl[0].occ, "drain step with an empty chain")

endmodule

>>> hw/rtl/ssu_cell.sv
// one cell of the sorted insertion chain: holds one value and its occupancy
// depends on ssu_pkg
module ssu_cell #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         ins_en,
   input  logic                         shift_en,
   input  logic signed [VALUE_BITS-1:0] new_val,
   input  ssu_pkg::link_type            left_ctl,
   input  logic signed [VALUE_BITS-1:0] left_val,
   input  logic                         right_occ,
   input  logic signed [VALUE_BITS-1:0] right_val,
   output ssu_pkg::link_type            ctl,
   output logic signed [VALUE_BITS-1:0] val,
   output logic                         eq
);

   logic                         occ_ff;
   logic                         occ_in;
   logic signed [VALUE_BITS-1:0] val_ff;
   logic signed [VALUE_BITS-1:0] val_in;
   logic                         gt;
   logic                         take;

   // compare held value against the broadcast value
   assign gt   = occ_ff & (val_ff > new_val);
   assign eq   = occ_ff & (val_ff == new_val);
   assign take = ins_en & (gt | (~occ_ff & left_ctl.occ));

   // shift left on drain, otherwise insert or shift right
   always_comb begin
      occ_in = occ_ff;
      val_in = val_ff;
      if (shift_en) begin
         occ_in = right_occ;
         val_in = right_val;
      end else if (take) begin
         occ_in = 1'b1;
         val_in = left_ctl.gt ? left_val : new_val;
      end
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // held value
   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign ctl.occ = occ_ff;
   assign ctl.gt  = gt;
   assign val     = val_ff;

endmodule
